FILE: src/serial_frame_deframer_crc16_assert.svh
// Assertion macros used by the deframer checker
`ifndef SERIAL_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_CRC16_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFDC16_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFDC16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sfdc16_pkg.sv
// Shared constants, types and CRC function of the serial frame deframer
package sfdc16_pkg;

    localparam int FRAME_BUFFER_BYTES = 256;

    localparam logic [7:0]  HDR_FIRST  = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'h55;
    localparam logic [7:0]  LEN_LIMIT  = 8'(FRAME_BUFFER_BYTES - 3);
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_SEEK_A = 4'b0001,
        ST_SEEK_B = 4'b0010,
        ST_LENGTH = 4'b0100,
        ST_BODY   = 4'b1000
    } state_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_len;
    } result_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: src/sfdc16_if.sv
// Valid/ready channel interfaces for received bytes and deframer results
interface sfdc16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfdc16_out_if;
    import sfdc16_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_len;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output frame_len, input ready);
    modport sink (input valid, input result_kind, input payload_byte,
                  input payload_index, input frame_len, output ready);
endinterface

FILE: src/sfdc16_core.sv
// Frame hunt state machine, length check, payload indexing and running CRC
module sfdc16_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output sfdc16_pkg::result_t res
);
    import sfdc16_pkg::*;

    state_t      state_reg, state_next;
    logic [7:0]  length_reg, length_next;
    logic [8:0]  count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;

    always_comb
    begin
        state_next        = state_reg;
        length_next       = length_reg;
        count_next        = count_reg;
        crc_next          = crc_reg;
        crc_low_next      = crc_low_reg;
        res_valid         = 1'b0;
        res.result_kind   = KIND_PAYLOAD;
        res.payload_byte  = 8'h00;
        res.payload_index = 8'h00;
        res.frame_len     = length_reg;
        if (take)
        begin
            case (state_reg)
                ST_SEEK_A:
                begin
                    if (rx_byte == HDR_FIRST)
                        state_next = ST_SEEK_B;
                end
                ST_SEEK_B:
                begin
                    state_next = (rx_byte == HDR_SECOND) ? ST_LENGTH : ST_SEEK_A;
                end
                ST_LENGTH:
                begin
                    if (rx_byte <= LEN_LIMIT)
                    begin
                        length_next = rx_byte;
                        count_next  = 9'h000;
                        crc_next    = crc_byte(CRC_INIT, rx_byte);
                        state_next  = ST_BODY;
                    end
                    else
                        state_next = ST_SEEK_A;
                end
                ST_BODY:
                begin
                    if (count_reg < {1'b0, length_reg})
                    begin
                        res_valid         = 1'b1;
                        res.payload_byte  = rx_byte;
                        res.payload_index = count_reg[7:0];
                        crc_next          = crc_byte(crc_reg, rx_byte);
                        count_next        = count_reg + 9'd1;
                    end
                    else if (count_reg == {1'b0, length_reg})
                    begin
                        crc_low_next = rx_byte;
                        count_next   = count_reg + 9'd1;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = ({rx_byte, crc_low_reg} == crc_reg) ? KIND_GOOD
                                                                               : KIND_BAD;
                        state_next      = ST_SEEK_A;
                        count_next      = 9'h000;
                    end
                end
                default:
                begin
                    state_next = ST_SEEK_A;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SEEK_A;
            length_reg  <= 8'h00;
            count_reg   <= 9'h000;
            crc_reg     <= CRC_INIT;
            crc_low_reg <= 8'h00;
        end
        else
        begin
            state_reg   <= state_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
        end
    end

endmodule

FILE: src/sfdc16_outq.sv
// Two-entry result buffer: output register plus skid register
module sfdc16_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfdc16_pkg::result_t push_data,
    output logic                full,
    sfdc16_out_if.source        res
);
    import sfdc16_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop  = main_valid_reg & res.ready;
    assign full = skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (main_valid_reg)
        begin
            if (pop)
            begin
                main_valid_next = push;
                if (push)
                    main_next = push_data;
            end
            else if (push)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            main_next       = push_data;
            main_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign res.valid         = main_valid_reg;
    assign res.result_kind   = main_reg.result_kind;
    assign res.payload_byte  = main_reg.payload_byte;
    assign res.payload_index = main_reg.payload_index;
    assign res.frame_len     = main_reg.frame_len;

endmodule

FILE: src/serial_frame_deframer_crc16.sv
// Serial frame deframer top level: byte in, payload bytes and frame-end status out
// Receives frames of the form 0xAA 0x55, length, payload, CRC low, CRC high, one byte per
// item, and takes a byte in every clock cycle while the output keeps up. Each payload byte
// comes out with its index and the announced length in the cycle after it is accepted when
// the output is free; after the second CRC byte a frame-end item reports good or bad
// CRC-16 (poly 0x1021, init 0xFFFF, over length and payload). Header, length and low CRC
// bytes give no item. Lengths above 253 drop the frame silently. Results go through a
// two-entry output buffer, so one more result is taken after the output stalls; rx.ready
// falls only when both entries are full and rises the cycle after the output takes an item.
module serial_frame_deframer_crc16 (
    input  logic         clk,
    input  logic         rst_n,
    sfdc16_in_if.sink    rx,
    sfdc16_out_if.source res
);
    import sfdc16_pkg::*;

    logic    full;
    logic    take;
    logic    core_valid;
    result_t core_res;

    assign rx.ready = ~full;
    assign take     = rx.valid & ~full;

    sfdc16_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx.rx_byte),
        .res_valid (core_valid),
        .res       (core_res)
    );

    sfdc16_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_data (core_res),
        .full      (full),
        .res       (res)
    );

endmodule

FILE: src/sfdc16_chk.sv
// Port-level checker for the serial frame deframer, bound to the top level
`include "serial_frame_deframer_crc16_assert.svh"

module sfdc16_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] result_kind,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index,
    input logic [7:0] frame_len
);
    import sfdc16_pkg::*;

    logic res_stall;
    logic res_end;
    logic res_payload;
    logic end_fields_zero;
    logic index_ok;
    logic in_take;

    assign res_stall       = res_valid && !res_ready;
    assign res_end         = res_valid && (result_kind != KIND_PAYLOAD);
    assign res_payload     = res_valid && (result_kind == KIND_PAYLOAD);
    assign end_fields_zero = (payload_byte == 8'h00) && (payload_index == 8'h00);
    assign index_ok        = (payload_index < frame_len) && (frame_len <= LEN_LIMIT);
    assign in_take         = rx_valid && rx_ready;

    `SFDC16_ASSERT_NEXT(a_res_hold, res_stall, res_valid, "result dropped while stalled")
    `SFDC16_ASSERT_NOW(a_end_zero, res_end, end_fields_zero, "frame end with payload fields set")
    `SFDC16_ASSERT_NOW(a_index_range, res_payload, index_ok, "payload index outside frame")
    `SFDC16_ASSERT_NOW(a_no_spurious, res_valid, $past(res_valid || in_take), "result unbidden")

endmodule

bind serial_frame_deframer_crc16 sfdc16_chk u_sfdc16_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx.valid),
    .rx_ready      (rx.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .result_kind   (res.result_kind),
    .payload_byte  (res.payload_byte),
    .payload_index (res.payload_index),
    .frame_len     (res.frame_len)
);

FILE: verif/tb_serial_frame_deframer_crc16.sv
// Self-checking testbench for the serial frame deframer with CRC-16 check
module tb_serial_frame_deframer_crc16;
    timeunit 1ns;
    timeprecision 1ps;

    import sfdc16_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 16;

    class deframe_scoreboard;
        state_t      hunt;
        logic [7:0]  announced_len;
        logic [8:0]  body_count;
        logic [15:0] crc_run;
        logic [7:0]  crc_low;
        result_t     awaited[$];
        int          errors;
        int          checked;
        int          good_ends;
        int          bad_ends;

        function new();
            hunt = ST_SEEK_A;
            announced_len = 8'd0;
            body_count = 9'd0;
            crc_run = CRC_INIT;
            crc_low = 8'd0;
            errors = 0;
            checked = 0;
            good_ends = 0;
            bad_ends = 0;
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[15] ^ data[i];
                c = {c[14:0], 1'b0};
                if (fb)
                begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void note_input(input logic [7:0] b);
            result_t r;
            case (hunt)
                ST_SEEK_A:
                begin
                    if (b == HDR_FIRST)
                    begin
                        hunt = ST_SEEK_B;
                    end
                end
                ST_SEEK_B:
                begin
                    hunt = (b == HDR_SECOND) ? ST_LENGTH : ST_SEEK_A;
                end
                ST_LENGTH:
                begin
                    if (b <= LEN_LIMIT)
                    begin
                        announced_len = b;
                        body_count = 9'd0;
                        crc_run = crc_step(CRC_INIT, b);
                        hunt = ST_BODY;
                    end
                    else
                    begin
                        hunt = ST_SEEK_A;
                    end
                end
                default:
                begin
                    if (body_count < {1'b0, announced_len})
                    begin
                        r.result_kind = KIND_PAYLOAD;
                        r.payload_byte = b;
                        r.payload_index = body_count[7:0];
                        r.frame_len = announced_len;
                        awaited.push_back(r);
                        crc_run = crc_step(crc_run, b);
                        body_count = body_count + 9'd1;
                    end
                    else if (body_count == {1'b0, announced_len})
                    begin
                        crc_low = b;
                        body_count = body_count + 9'd1;
                    end
                    else
                    begin
                        r.result_kind = ({b, crc_low} == crc_run) ? KIND_GOOD : KIND_BAD;
                        r.payload_byte = 8'd0;
                        r.payload_index = 8'd0;
                        r.frame_len = announced_len;
                        awaited.push_back(r);
                        hunt = ST_SEEK_A;
                        body_count = 9'd0;
                    end
                end
            endcase
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: result_kind %0d payload_byte %0d frame_len %0d",
                       got.result_kind, got.payload_byte, got.frame_len);
                errors++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.result_kind == KIND_GOOD)
            begin
                good_ends++;
            end
            if (want.result_kind == KIND_BAD)
            begin
                bad_ends++;
            end
            if (got.result_kind !== want.result_kind)
            begin
                $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
                errors++;
            end
            if (got.payload_byte !== want.payload_byte)
            begin
                $error("payload_byte: expected %0d, got %0d", want.payload_byte,
                       got.payload_byte);
                errors++;
            end
            if (got.payload_index !== want.payload_index)
            begin
                $error("payload_index: expected %0d, got %0d", want.payload_index,
                       got.payload_index);
                errors++;
            end
            if (got.frame_len !== want.frame_len)
            begin
                $error("frame_len: expected %0d, got %0d", want.frame_len, got.frame_len);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sfdc16_in_if  rx_ch ();
    sfdc16_out_if res_ch ();

    serial_frame_deframer_crc16 u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    deframe_scoreboard sb;
    result_t           seen_result;
    logic [7:0]        frame_body[$];
    int                items_sent;
    int                cycle_count;
    bit                quiet_tx;
    bit                quiet_rx;

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                seen_result.result_kind = res_ch.result_kind;
                seen_result.payload_byte = res_ch.payload_byte;
                seen_result.payload_index = res_ch.payload_index;
                seen_result.frame_len = res_ch.frame_len;
                sb.check_result(seen_result);
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                sb.note_input(rx_ch.rx_byte);
            end
        end
    end

    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet_rx ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        items_sent++;
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        for (int i = 0; i < len; i++)
        begin
            frame_body.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // keep < 0 sends the whole frame, otherwise only its first keep bytes
    task automatic send_frame(input bit bad_crc, input int keep);
        logic [15:0] crc;
        logic [7:0]  stream[$];
        int          n;
        crc = deframe_scoreboard::crc_step(CRC_INIT, 8'(frame_body.size()));
        foreach (frame_body[i])
        begin
            crc = deframe_scoreboard::crc_step(crc, frame_body[i]);
        end
        if (bad_crc)
        begin
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        end
        stream.push_back(HDR_FIRST);
        stream.push_back(HDR_SECOND);
        stream.push_back(8'(frame_body.size()));
        foreach (frame_body[i])
        begin
            stream.push_back(frame_body[i]);
        end
        stream.push_back(crc[7:0]);
        stream.push_back(crc[15:8]);
        n = (keep < 0 || keep > stream.size()) ? stream.size() : keep;
        for (int i = 0; i < n; i++)
        begin
            send_byte(stream[i]);
        end
    endtask

    task automatic wait_for_results();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.awaited.size() != 0);
    endtask

    initial
    begin
        int pick;
        int len;
        int next_switch;
        bit paused;
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'd0;
        items_sent = 0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        paused = 1'b0;
        next_switch = 64;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00);
        frame_body.delete();
        send_frame(1'b0, -1);
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(LEN_LIMIT + 8'd1);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(8'hFF);
        frame_body = {8'hFF, 8'h00};
        send_frame(1'b0, -1);
        frame_body = {8'h80};
        send_frame(1'b1, -1);
        wait_for_results();

        fill_body(LEN_LIMIT);
        send_frame(1'b0, -1);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= next_switch)
            begin
                quiet_tx = ($urandom_range(0, 3) == 0);
                quiet_rx = ($urandom_range(0, 3) == 0);
                next_switch = next_switch + 64;
            end
            if (!paused && items_sent > ITEM_TARGET / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                len = ($urandom_range(0, 79) == 0) ? $urandom_range(100, LEN_LIMIT)
                                                   : $urandom_range(0, 12);
                fill_body(len);
                send_frame($urandom_range(0, 4) == 0, -1);
            end
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
            begin
                send_byte(HDR_FIRST);
                send_byte(($urandom_range(0, 1) == 0) ? HDR_FIRST
                                                      : 8'($urandom_range(0, 255)));
            end
            else if (pick < 93)
            begin
                send_byte(HDR_FIRST);
                send_byte(HDR_SECOND);
                send_byte(8'($urandom_range(LEN_LIMIT + 1, 255)));
            end
            else
            begin
                len = $urandom_range(1, 12);
                fill_body(len);
                send_frame(1'b0, $urandom_range(3, len + 4));
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d received bytes over %0d cycles with random gaps and stalls.",
                 items_sent, cycle_count);
        $display("Checked %0d results: %0d payload bytes, %0d good and %0d bad frame ends.",
                 sb.checked, sb.checked - sb.good_ends - sb.bad_ends, sb.good_ends,
                 sb.bad_ends);
        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/sfdc16_pkg.sv
src/sfdc16_if.sv
src/sfdc16_core.sv
src/sfdc16_outq.sv
src/serial_frame_deframer_crc16.sv
src/sfdc16_chk.sv
verif/tb_serial_frame_deframer_crc16.sv
